// ===== hw/rtl/aes128_block_encrypt_top_macros.svh =====
// Assertion macros for the AES-128 block encryption core.
// Included by the top level; depends on nothing else.
`ifndef AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define AES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define AES_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AES_ASSERT(lbl, clk, rst_n, prop, msg)
`define AES_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/aes128_pkg.sv =====
// Package for the AES-128 block encryption core: beat types, sequencer
// states, register indexes and the round and key-schedule functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aes128_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned RndW = 4;
  localparam logic [RndW-1:0] FirstRound = 4'd1;
  localparam logic [RndW-1:0] LastRound = 4'd10;

  typedef struct packed {
    logic [HalfW-1:0] plain_high;
    logic [HalfW-1:0] plain_low;
  } aes_in_t;

  typedef struct packed {
    logic [HalfW-1:0] cipher_high;
    logic [HalfW-1:0] cipher_low;
  } aes_out_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } aes_state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Multiply by x in GF(2^8) with the AES polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant of round 1 to 10.
  function automatic logic [7:0] rcon(input logic [RndW-1:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Round key of round rnd from the round key of the round before.
  function automatic logic [BlockW-1:0] next_round_key(input logic [BlockW-1:0] rk,
                                                       input logic [RndW-1:0] rnd);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    t  = t ^ {rcon(rnd), 24'h000000};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // One cipher round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
  // Byte n sits at bits 127-8n down and lies in row n mod 4, column n div 4.
  function automatic logic [BlockW-1:0] cipher_round(input logic [BlockW-1:0] s,
                                                     input logic [BlockW-1:0] rk,
                                                     input logic last);
    logic [7:0] a [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [BlockW-1:0] sr;
    logic [BlockW-1:0] mc;
    for (int i = 0; i < 16; i++) begin
      a[i] = s[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4+r] = sbox(a[((c + r) & 3)*4 + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[c*4+0] = xtime(t[c*4+0]) ^ xtime(t[c*4+1]) ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      m[c*4+1] = xtime(t[c*4+1]) ^ xtime(t[c*4+2]) ^ t[c*4+2] ^ t[c*4+0] ^ t[c*4+3];
      m[c*4+2] = xtime(t[c*4+2]) ^ xtime(t[c*4+3]) ^ t[c*4+3] ^ t[c*4+0] ^ t[c*4+1];
      m[c*4+3] = xtime(t[c*4+3]) ^ xtime(t[c*4+0]) ^ t[c*4+0] ^ t[c*4+1] ^ t[c*4+2];
    end
    for (int i = 0; i < 16; i++) begin
      sr[127-8*i -: 8] = t[i];
      mc[127-8*i -: 8] = m[i];
    end
    return (last ? sr : mc) ^ rk;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aes128_block_encrypt_top.sv =====
// AES-128 encryption core: one 128-bit block per input beat, ECB mode.
// Depends on aes128_pkg and aes128_block_encrypt_top_macros.svh.
//
// Usage: the cipher key is written through cfg_we_i / cfg_idx_i / cfg_data_i,
// index 0 for key bytes 0 to 7 and index 1 for key bytes 8 to 15, while the
// core is idle. A plaintext beat is taken on in_valid_i and in_ready_o; the
// ciphertext beat leaves on out_valid_o and out_ready_i.
// Sequence: the accepting edge applies the initial key addition, then one
// round per cycle follows up to the last round, which waits while the output
// register is still full; the last round writes the result to that register.
// The next block can be taken once the last round is done, not while a block
// is in its rounds. The round unit (sixteen S-boxes and MixColumns) and the
// on-the-fly key schedule (four S-boxes) are shared by all rounds.
// The round keys are derived again from the key registers for every block,
// so no expanded key memory has to be filled after a key write.
// Reset clears the key registers to zero, empties the output register and
// returns the sequencer to idle.
// Stalls: a finished ciphertext sits in the output register. A new block is
// still accepted meanwhile; if it finishes while the old result has not been
// taken, the core holds its last round until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_encrypt_top_macros.svh"

module aes128_block_encrypt_top
  import aes128_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [HalfW-1:0] cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire aes_in_t       in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output aes_out_t           out_data_o
);

  // Key registers.
  logic [HalfW-1:0] key_high_q;
  logic [HalfW-1:0] key_low_q;

  // Sequencer and datapath registers.
  aes_state_e        state_q, state_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic [BlockW-1:0] blk_q, blk_d;
  logic [BlockW-1:0] rk_q, rk_d;
  logic              out_valid_q, out_valid_d;
  logic [BlockW-1:0] out_q, out_d;

  // Control decoded from the sequencer state.
  logic              accept;
  logic              last_round;
  logic              out_free;
  logic              advance;
  logic [BlockW-1:0] cipher_key;
  logic [BlockW-1:0] rk_next;
  logic [BlockW-1:0] blk_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cipher_key = {key_high_q, key_low_q};
  assign rk_next    = next_round_key(rk_q, rnd_q);
  assign blk_next   = cipher_round(blk_q, rk_next, last_round);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && last_round) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    accept      = in_ready_o && in_valid_i;
    last_round  = (rnd_q == LastRound);
    out_free    = !out_valid_q || out_ready_i;
    advance     = (state_q == ST_RUN) && (!last_round || out_free);

    rnd_d       = rnd_q;
    blk_d       = blk_q;
    rk_d        = rk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (accept) begin
      // Initial AddRoundKey with the cipher key itself.
      blk_d = in_data_i ^ cipher_key;
      rk_d  = cipher_key;
      rnd_d = FirstRound;
    end else if (advance) begin
      blk_d = blk_next;
      rk_d  = rk_next;
      rnd_d = rnd_q + 4'd1;
      if (last_round) begin
        out_d       = blk_next;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= FirstRound;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    rk_q  <= rk_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = aes_out_t'(out_q);

  // A taken block always starts its rounds at round one.
  `AES_ASSERT(a_start_round, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == ST_RUN && rnd_q == FirstRound), "block did not start at round one")
  // The round counter never leaves the range one to ten while running.
  `AES_ASSERT_NEVER(a_round_range, clk_i, rst_ni, (state_q == ST_RUN && (rnd_q < FirstRound || rnd_q > LastRound)), "round counter out of range")
  // A fresh result only appears right after the last round was computed.
  `AES_ASSERT(a_result_after_last, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == ST_RUN && rnd_q == LastRound), "result without a final round")

endmodule

`default_nettype wire
